[rtl/array_list_engine_macros.svh]
// Assertion macros used by the checker of the list engine.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// Concurrent assertion on the engine clock, off while reset is held.
`define ALE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Overlapping implication built on the macro above.
`define ALE_ASSERT_IMP(label, ante, cons, msg) \
    `ALE_ASSERT(label, (ante) |-> (cons), msg)

`endif

[rtl/ale_pkg.sv]
// Package with the types and constants of the list engine.
package ale_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = 6;
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DUMP_RD,
        S_DUMP_DATA,
        S_EMIT
    } t_state;

endpackage

[rtl/ale_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/array_list_engine.sv]
// Top level of the list engine: sequencer, entry count and output register.
//
// Input channel: i_in_valid / o_in_ready carry one item (operation, index,
// value). Output channel: o_out_valid / i_out_ready carry result items.
// Append, update, delete and a rejected operation give one result, marked last.
// o_in_ready falls on acceptance and returns when the sequencer leaves its
// emit state, which needs a free output register. A delete that succeeds
// walks the single RAM port pair once per moved entry. A dump reads each
// entry through the same port pair in the dump-read, dump-data and emit
// states in turn, and gives count results, the final one marked last; a
// dump of an empty list gives one result with status empty.
// Reset clears the entry count, the sequencer state and the output valid
// flag; the RAM is not cleared, and only entries below the count are ever used.
// The output register holds a result until it is taken. While it is full
// and the receiver stalls, the sequencer waits in its emit state and takes
// no new item.
module array_list_engine
    import ale_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_operation,
    input  logic [ADDR_W-1:0]   i_index,
    input  logic [DATA_W-1:0]   i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [DATA_W-1:0]   o_entry_value,
    output logic [ADDR_W-1:0]   o_entry_position,
    output logic [CNT_W-1:0]    o_count_after,
    output logic                o_last
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [ADDR_W-1:0]   r_ptr, n_ptr;
    logic [ADDR_W-1:0]   r_left, n_left;
    t_status             r_res_status, n_res_status;
    logic [DATA_W-1:0]   r_res_value, n_res_value;
    logic [ADDR_W-1:0]   r_res_pos, n_res_pos;
    logic                r_res_last, n_res_last;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [DATA_W-1:0]   r_out_value, n_out_value;
    logic [ADDR_W-1:0]   r_out_pos, n_out_pos;
    logic [CNT_W-1:0]    r_out_count, n_out_count;
    logic                r_out_last, n_out_last;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic                in_acc;
    logic                idx_ok;
    t_op                 op;

    ale_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign op         = t_op'(i_operation);
    assign idx_ok     = ({1'b0, i_index} < r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_pos    <= n_res_pos;
        r_res_last   <= n_res_last;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_pos    = r_res_pos;
        n_res_last   = r_res_last;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_ptr;
        ram_wdata    = ram_rdata;
        ram_raddr    = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = ADDR_W'({1'b0, i_index} + CNT_W'(1));
                if (in_acc) begin
                    n_res_status = ST_OK;
                    n_res_value  = '0;
                    n_res_pos    = '0;
                    n_res_last   = 1'b1;
                    n_state      = S_EMIT;
                    unique case (op)
                        OP_APPEND: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[ADDR_W-1:0];
                                ram_wdata = i_value;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else if (!idx_ok) begin
                                n_res_status = ST_BADIDX;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                n_ptr   = i_index;
                                n_left  = ADDR_W'(r_count - CNT_W'(1) - {1'b0, i_index});
                                if (n_left != '0) begin
                                    n_state = S_SHIFT;
                                end
                            end
                        end
                        OP_UPDATE: begin
                            if (!idx_ok) begin
                                n_res_status = ST_BADIDX;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = i_index;
                                ram_wdata = i_value;
                            end
                        end
                        OP_DUMP: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_DUMP_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = ram_rdata;
                ram_raddr = r_ptr + ADDR_W'(2);
                n_ptr     = r_ptr + ADDR_W'(1);
                n_left    = r_left - ADDR_W'(1);
                if (r_left == ADDR_W'(1)) begin
                    n_state = S_EMIT;
                end
            end
            S_DUMP_RD: begin
                ram_raddr = r_ptr;
                n_state   = S_DUMP_DATA;
            end
            S_DUMP_DATA: begin
                n_res_status = ST_OK;
                n_res_value  = ram_rdata;
                n_res_pos    = r_ptr;
                n_res_last   = (({1'b0, r_ptr} + CNT_W'(1)) == r_count);
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_out_pos    = r_res_pos;
                    n_out_count  = r_count;
                    n_out_last   = r_res_last;
                    if (r_res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + ADDR_W'(1);
                        n_state = S_DUMP_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_value    = r_out_value;
    assign o_entry_position = r_out_pos;
    assign o_count_after    = r_out_count;
    assign o_last           = r_out_last;

endmodule

[rtl/ale_checker.sv]
// Port-level checker for the list engine, bound to its top level.
`include "array_list_engine_macros.svh"

module ale_checker
    import ale_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [1:0]          o_status,
    input  logic [DATA_W-1:0]   o_entry_value,
    input  logic [ADDR_W-1:0]   o_entry_position,
    input  logic [CNT_W-1:0]    o_count_after,
    input  logic                o_last
);

    `ALE_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_entry_value) && $stable(o_last), "result changed while stalled")
    `ALE_ASSERT(a_busy_after_accept, i_in_valid && o_in_ready |=> !o_in_ready, "item accepted while busy")
    `ALE_ASSERT_IMP(a_count_range, o_out_valid, o_count_after <= CNT_W'(CAPACITY), "count above capacity")
    `ALE_ASSERT_IMP(a_burst_ok, o_out_valid && !o_last, o_status == ST_OK, "unmarked result without ok status")
    `ALE_ASSERT_IMP(a_err_zero, o_out_valid && o_status != ST_OK, o_entry_value == '0 && o_entry_position == '0, "error result carries entry data")

endmodule

bind array_list_engine ale_checker u_ale_checker (.*);

[tb/tb_array_list_engine.sv]
// Self-checking testbench of the list engine: random handshakes, list prediction, result check.
`timescale 1ns / 1ps

module tb_array_list_engine;
    import ale_pkg::*;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  idx;
        logic [DATA_W-1:0]  val;
    } t_list_op;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  value;
        logic [ADDR_W-1:0]  pos;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_list_reply;

    typedef enum int {
        PH_FILL,
        PH_MIX_A,
        PH_DRAIN,
        PH_MIX_B
    } t_phase;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_operation = OP_APPEND;
    logic [ADDR_W-1:0]  i_index = '0;
    logic [DATA_W-1:0]  i_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic [DATA_W-1:0]  o_entry_value;
    logic [ADDR_W-1:0]  o_entry_position;
    logic [CNT_W-1:0]   o_count_after;
    logic               o_last;

    t_list_op       ops_to_send[$];
    t_list_op       op_on_bus;
    t_list_reply    list_replies[$];
    logic [DATA_W-1:0] list_mem [0:CAPACITY-1];
    int             list_len = 0;
    int             plan_len = 0;
    int             items_taken = 0;
    int             replies_seen = 0;
    int             dumps_seen = 0;
    int             full_hits = 0;
    int             mismatches = 0;
    logic           steady;

    array_list_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_index          (i_index),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_entry_value    (o_entry_value),
        .o_entry_position (o_entry_position),
        .o_count_after    (o_count_after),
        .o_last           (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Neither side idles while this window of items passes.
    assign steady = (items_taken >= 150) && (items_taken < 210);

    function automatic void list_apply(t_list_op item);
        t_list_reply r;
        int k;
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        case (item.op)
            OP_APPEND: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                    full_hits++;
                end else begin
                    list_mem[list_len] = item.val;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(item.idx) >= list_len) begin
                    r.status = ST_BADIDX;
                end else begin
                    for (k = int'(item.idx); k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            OP_UPDATE: begin
                if (int'(item.idx) >= list_len)
                    r.status = ST_BADIDX;
                else
                    list_mem[item.idx] = item.val;
            end
            default: begin
                dumps_seen++;
                if (list_len == 0)
                    r.status = ST_EMPTY;
            end
        endcase
        if (item.op == OP_DUMP && list_len > 0) begin
            for (k = 0; k < list_len; k++) begin
                r.value = list_mem[k];
                r.pos = ADDR_W'(k);
                r.count = CNT_W'(list_len);
                r.last = (k + 1 == list_len);
                list_replies.push_back(r);
            end
        end else begin
            r.count = CNT_W'(list_len);
            list_replies.push_back(r);
        end
    endfunction

    task automatic plan_op(t_op op, logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
        t_list_op item;
        item.op = op;
        item.idx = idx;
        item.val = val;
        ops_to_send.push_back(item);
        if (op == OP_APPEND && plan_len < CAPACITY)
            plan_len++;
        else if (op == OP_DELETE && plan_len > 0 && int'(idx) < plan_len)
            plan_len--;
    endtask

    function automatic logic [ADDR_W-1:0] pick_index();
        if (plan_len > 0 && $urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return ADDR_W'(plan_len - 1);
                default: return ADDR_W'($urandom_range(0, plan_len - 1));
            endcase
        end
        return ADDR_W'($urandom_range(0, CAPACITY - 1));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin : drive_ops
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                list_apply(op_on_bus);
                items_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (ops_to_send.size() > 0 && (steady || $urandom_range(0, 99) >= 34)) begin
                    op_on_bus = ops_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= op_on_bus.op;
                    i_index <= op_on_bus.idx;
                    i_value <= op_on_bus.val;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_replies
        t_list_reply got;
        t_list_reply want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.status = t_status'(o_status);
                got.value = o_entry_value;
                got.pos = o_entry_position;
                got.count = o_count_after;
                got.last = o_last;
                replies_seen++;
                if (list_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: st %0d val %h pos %0d cnt %0d last %0b",
                                 $realtime, got.status, got.value, got.pos, got.count,
                                 got.last);
                end else begin
                    want = list_replies.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result %0d expected st %0d val %h pos %0d cnt %0d last %0b",
                                     $realtime, replies_seen, want.status, want.value,
                                     want.pos, want.count, want.last);
                            $display("%0t: result %0d actual   st %0d val %h pos %0d cnt %0d last %0b",
                                     $realtime, replies_seen, got.status, got.value,
                                     got.pos, got.count, got.last);
                        end
                    end
                end
            end
            i_out_ready <= steady || ($urandom_range(0, 99) >= 34);
        end
    end

    initial begin : run_test
        int roll;
        int directed_n;
        int phase_no;

        // Empty list corner cases, field extremes, bad indexes and deletes at each end.
        plan_op(OP_DUMP, '0, '0);
        plan_op(OP_DELETE, '0, '0);
        plan_op(OP_UPDATE, '0, 32'h1111_1111);
        plan_op(OP_APPEND, 6'd63, 32'h8000_0000);
        plan_op(OP_APPEND, '0, 32'h7fff_ffff);
        plan_op(OP_APPEND, '0, 32'h0000_0000);
        plan_op(OP_APPEND, '0, 32'hffff_ffff);
        plan_op(OP_APPEND, '0, 32'h1234_5678);
        plan_op(OP_UPDATE, 6'd4, 32'ha5a5_a5a5);
        plan_op(OP_UPDATE, 6'd5, 32'h5a5a_5a5a);
        plan_op(OP_UPDATE, 6'd63, 32'hdead_beef);
        plan_op(OP_DELETE, 6'd63, '0);
        plan_op(OP_DELETE, 6'd5, '0);
        plan_op(OP_DUMP, '0, 32'hffff_ffff);
        plan_op(OP_DELETE, 6'd2, '0);
        plan_op(OP_DELETE, 6'd3, '0);
        plan_op(OP_DELETE, 6'd0, '0);
        plan_op(OP_DUMP, '0, '0);
        plan_op(OP_APPEND, '0, 32'h5a5a_5a5a);
        plan_op(OP_DUMP, 6'd63, '0);
        plan_op(OP_DELETE, 6'd0, '0);
        plan_op(OP_DELETE, 6'd1, '0);
        plan_op(OP_DELETE, 6'd0, '0);
        plan_op(OP_DELETE, 6'd0, '0);
        plan_op(OP_DUMP, '0, '0);
        directed_n = ops_to_send.size();

        phase_no = 0;
        while (ops_to_send.size() < directed_n + 300) begin
            case (t_phase'(phase_no % 4))
                PH_FILL: begin
                    while (plan_len < CAPACITY) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 85)
                            plan_op(OP_APPEND, pick_index(), pick_value());
                        else if (roll < 90)
                            plan_op(OP_UPDATE, pick_index(), pick_value());
                        else if (roll < 95)
                            plan_op(OP_DELETE, pick_index(), pick_value());
                        else
                            plan_op(OP_DUMP, pick_index(), pick_value());
                    end
                    plan_op(OP_APPEND, pick_index(), pick_value());
                    plan_op(OP_APPEND, pick_index(), pick_value());
                    plan_op(OP_DUMP, pick_index(), pick_value());
                end
                PH_DRAIN: begin
                    while (plan_len > 0) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 85)
                            plan_op(OP_DELETE, pick_index(), pick_value());
                        else if (roll < 92)
                            plan_op(OP_UPDATE, pick_index(), pick_value());
                        else if (roll < 96)
                            plan_op(OP_DUMP, pick_index(), pick_value());
                        else
                            plan_op(OP_APPEND, pick_index(), pick_value());
                    end
                    plan_op(OP_DELETE, pick_index(), pick_value());
                    plan_op(OP_UPDATE, pick_index(), pick_value());
                    plan_op(OP_DUMP, pick_index(), pick_value());
                end
                default: begin
                    repeat (20)
                        plan_op(t_op'($urandom_range(0, 3)), pick_index(), pick_value());
                end
            endcase
            phase_no++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_to_send.size() != 0 || i_in_valid || list_replies.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("Ran %0d list operations (%0d dumps, %0d appends to a full list).",
                 items_taken, dumps_seen, full_hits);
        $display("Checked %0d result items, %0d of them wrong or unexpected.",
                 replies_seen, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("Timed out with %0d operations queued and %0d results outstanding.",
                 ops_to_send.size(), list_replies.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
